// ===== rtl/core/pwm_pulse_pattern_player_defines.svh =====
// Assertion macros shared by the pulse pattern player RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PWM_PULSE_PATTERN_PLAYER_DEFINES_SVH
`define PWM_PULSE_PATTERN_PLAYER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ppp_pkg.sv =====
`default_nettype none

package ppp_pkg;

    // Pattern table slots and the length cap
    localparam int ENTRY_SLOTS   = 4;
    localparam int PATTERN_DEPTH = 4;
    localparam int LEN_CAP       = (PATTERN_DEPTH < ENTRY_SLOTS) ? PATTERN_DEPTH : ENTRY_SLOTS;

    // Default tick count of one on/pause unit
    localparam int UNIT_TICKS_DEF = 100;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Element timing widths
    localparam int ELAPSED_W = 16;
    localparam int CYC_W     = 9;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_REPEAT_COUNT   = 3'd1,
        REG_ENTRY_0        = 3'd2,
        REG_ENTRY_1        = 3'd3,
        REG_ENTRY_2        = 3'd4,
        REG_ENTRY_3        = 3'd5
    } t_reg_idx;

    // Command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_ON    = 2'd2,
        CMD_OFF   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] drive_level;
        logic       busy_res;
    } t_out_item;

    // Pattern settings seen by the player core
    typedef struct packed {
        logic [2:0]                  plen;
        logic [7:0]                  repeat_count;
        logic [ENTRY_SLOTS-1:0][7:0] level;
    } t_pat_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/pwm_pulse_pattern_player.sv =====
// Pulse pattern player: one result per item; input register, then result register.
// 1 item per cycle unless output stalls; player state updates in one pass through the core.
// Element bounds (units times ticks) are computed on the configuration write.
// Synchronous active-low reset: idle, steady off, drive 0, length 1, repeat 1, table 0.
`default_nettype none
`include "pwm_pulse_pattern_player_defines.svh"

module pwm_pulse_pattern_player
    import ppp_pkg::*;
#(
    parameter int UNIT_TICKS = UNIT_TICKS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Widest element bound: (255 + 255) units
    localparam int BND_W = $clog2(2 * 255 * UNIT_TICKS + 1);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             w_step;
    t_out_item        w_result;
    t_pat_cfg         w_cfg;
    logic [BND_W-1:0] w_on_bound   [ENTRY_SLOTS];
    logic [BND_W-1:0] w_full_bound [ENTRY_SLOTS];

    // Item moves from the input register to the result register
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ppp_cfg_regs #(
        .UNIT_TICKS (UNIT_TICKS),
        .BND_W      (BND_W)
    ) u_cfg_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_cfg        (w_cfg),
        .o_on_bound   (w_on_bound),
        .o_full_bound (w_full_bound)
    );

    ppp_play_core #(
        .BND_W (BND_W)
    ) u_play_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_item       (r_in_item),
        .i_cfg        (w_cfg),
        .i_on_bound   (w_on_bound),
        .i_full_bound (w_full_bound),
        .o_result     (w_result)
    );

    `PPP_ASSERT_NEXT(a_stall_keeps_item, r_in_valid && r_out_valid && !i_out_ready, r_in_valid, "held item dropped during output stall")
    `PPP_ASSERT_NEXT(a_step_gives_result, w_step, r_out_valid, "processed item produced no result")

endmodule

`default_nettype wire

// ===== rtl/core/ppp_cfg_regs.sv =====
`default_nettype none

module ppp_cfg_regs
    import ppp_pkg::*;
#(
    parameter int UNIT_TICKS = UNIT_TICKS_DEF,
    parameter int BND_W      = 19
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_pat_cfg                   o_cfg,
    output logic [BND_W-1:0]           o_on_bound   [ENTRY_SLOTS],
    output logic [BND_W-1:0]           o_full_bound [ENTRY_SLOTS]
);

    logic [2:0]       r_plen;
    logic [7:0]       r_repeat;
    logic [7:0]       r_level      [ENTRY_SLOTS];
    logic [BND_W-1:0] r_on_bound   [ENTRY_SLOTS];
    logic [BND_W-1:0] r_full_bound [ENTRY_SLOTS];

    logic             w_entry_we;
    logic [1:0]       w_slot;
    logic [BND_W-1:0] n_on_bound;
    logic [BND_W-1:0] n_full_bound;

    // Decode the entry slot of a table write
    always_comb begin
        w_entry_we = 1'b0;
        w_slot     = 2'd0;
        case (i_cfg_index)
            REG_ENTRY_0: begin w_entry_we = i_cfg_we; w_slot = 2'd0; end
            REG_ENTRY_1: begin w_entry_we = i_cfg_we; w_slot = 2'd1; end
            REG_ENTRY_2: begin w_entry_we = i_cfg_we; w_slot = 2'd2; end
            REG_ENTRY_3: begin w_entry_we = i_cfg_we; w_slot = 2'd3; end
            default: begin w_entry_we = 1'b0; w_slot = 2'd0; end
        endcase
    end

    // Tick bounds of the element being written: on-time and on-time plus pause
    assign n_on_bound   = BND_W'(i_cfg_wdata[7:0]) * BND_W'(UNIT_TICKS);
    assign n_full_bound = (BND_W'(i_cfg_wdata[7:0]) + BND_W'(i_cfg_wdata[15:8]))
                          * BND_W'(UNIT_TICKS);

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= 3'd1;
            r_repeat <= 8'd1;
            for (int k = 0; k < ENTRY_SLOTS; k++) begin
                r_level[k]      <= '0;
                r_on_bound[k]   <= '0;
                r_full_bound[k] <= '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_PATTERN_LENGTH)) begin
                r_plen <= i_cfg_wdata[2:0];
            end
            if (i_cfg_we && (i_cfg_index == REG_REPEAT_COUNT)) begin
                r_repeat <= i_cfg_wdata[7:0];
            end
            for (int k = 0; k < ENTRY_SLOTS; k++) begin
                if (w_entry_we && (w_slot == 2'(k))) begin
                    r_level[k]      <= i_cfg_wdata[23:16];
                    r_on_bound[k]   <= n_on_bound;
                    r_full_bound[k] <= n_full_bound;
                end
            end
        end
    end

    always_comb begin
        o_cfg.plen         = r_plen;
        o_cfg.repeat_count = r_repeat;
        for (int k = 0; k < ENTRY_SLOTS; k++) begin
            o_cfg.level[k]  = r_level[k];
            o_on_bound[k]   = r_on_bound[k];
            o_full_bound[k] = r_full_bound[k];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ppp_play_core.sv =====
`default_nettype none
`include "pwm_pulse_pattern_player_defines.svh"

module ppp_play_core
    import ppp_pkg::*;
#(
    parameter int BND_W = 19
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire t_in_item         i_item,
    input  wire t_pat_cfg         i_cfg,
    input  wire logic [BND_W-1:0] i_on_bound   [ENTRY_SLOTS],
    input  wire logic [BND_W-1:0] i_full_bound [ENTRY_SLOTS],
    output t_out_item             o_result
);

    localparam int CMP_W = (BND_W > ELAPSED_W) ? BND_W : ELAPSED_W;
    localparam logic [CYC_W-1:0] CYC_ONE = CYC_W'(1);

    // Player state
    logic                 r_playing, n_playing;
    logic                 r_steady_on, n_steady_on;
    logic [1:0]           r_idx, n_idx;
    logic [CYC_W-1:0]     r_cyc, n_cyc;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [7:0]           r_drive, n_drive;

    // Element evaluation inputs and outputs
    logic [2:0]           w_len;
    logic [1:0]           e_idx;
    logic [CYC_W-1:0]     e_cyc;
    logic [ELAPSED_W-1:0] e_elapsed;
    logic                 w_in_range, w_is_last, w_hold, w_in_on;
    logic [BND_W-1:0]     w_total;
    logic [1:0]           a_idx;
    logic [CYC_W-1:0]     a_cyc;
    logic                 w_wrap, w_stop;
    logic [1:0]           ev_idx;
    logic [CYC_W-1:0]     ev_cyc;
    logic [ELAPSED_W-1:0] ev_elapsed;
    logic [7:0]           ev_drive;
    logic                 ev_playing;

    // Effective pattern length: zero reads as one, clamp to the table
    always_comb begin
        w_len = i_cfg.plen;
        if (w_len == 3'd0) begin
            w_len = 3'd1;
        end
        if (w_len > 3'(LEN_CAP)) begin
            w_len = 3'(LEN_CAP);
        end
    end

    // A start evaluates element 0 of cycle 1; a tick the current one
    always_comb begin
        if (i_item.cmd == CMD_START) begin
            e_idx     = 2'd0;
            e_cyc     = CYC_ONE;
            e_elapsed = '0;
        end else begin
            e_idx     = r_idx;
            e_cyc     = r_cyc;
            e_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + ELAPSED_W'(1);
        end
    end

    // Evaluate the element: stay in it, or move on to the next one
    always_comb begin
        w_in_range = {1'b0, e_idx} < w_len;
        w_is_last  = (e_cyc == {1'b0, i_cfg.repeat_count}) &&
                     (({1'b0, e_idx} + 3'd1) == w_len);
        // last element of the final cycle drops its pause
        w_total    = w_is_last ? i_on_bound[e_idx] : i_full_bound[e_idx];
        w_hold     = w_in_range && (CMP_W'(e_elapsed) < CMP_W'(w_total));
        w_in_on    = CMP_W'(e_elapsed) < CMP_W'(i_on_bound[e_idx]);

        a_idx  = e_idx + 2'd1;
        w_wrap = ({1'b0, a_idx} >= w_len) || (a_idx == 2'd0);
        a_cyc  = e_cyc + CYC_ONE;
        w_stop = w_wrap && ((a_cyc > {1'b0, i_cfg.repeat_count}) || (a_cyc == '0));

        if (w_hold) begin
            ev_idx     = e_idx;
            ev_cyc     = e_cyc;
            ev_elapsed = e_elapsed;
            ev_drive   = w_in_on ? i_cfg.level[e_idx] : 8'd0;
            ev_playing = 1'b1;
        end else begin
            ev_idx     = w_wrap ? 2'd0 : a_idx;
            ev_cyc     = w_wrap ? (w_stop ? CYC_ONE : a_cyc) : e_cyc;
            ev_elapsed = '0;
            ev_drive   = 8'd0;
            ev_playing = !w_stop;
        end
    end

    // Command handling
    always_comb begin
        n_playing   = r_playing;
        n_steady_on = r_steady_on;
        n_idx       = r_idx;
        n_cyc       = r_cyc;
        n_elapsed   = r_elapsed;
        n_drive     = r_drive;
        case (i_item.cmd)
            CMD_TICK: begin
                if (r_playing) begin
                    n_playing   = ev_playing;
                    n_steady_on = 1'b0;
                    n_idx       = ev_idx;
                    n_cyc       = ev_cyc;
                    n_elapsed   = ev_elapsed;
                    n_drive     = ev_drive;
                end
            end
            CMD_START: begin
                // start while playing or with no repeats is ignored
                if (!r_playing && (i_cfg.repeat_count != 8'd0)) begin
                    n_playing   = ev_playing;
                    n_steady_on = 1'b0;
                    n_idx       = ev_idx;
                    n_cyc       = ev_cyc;
                    n_elapsed   = ev_elapsed;
                    n_drive     = ev_drive;
                end
            end
            CMD_ON: begin
                n_drive     = i_item.level;
                n_steady_on = 1'b1;
            end
            default: begin
                n_drive     = 8'd0;
                n_steady_on = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing   <= 1'b0;
            r_steady_on <= 1'b0;
            r_idx       <= 2'd0;
            r_cyc       <= CYC_ONE;
            r_elapsed   <= '0;
            r_drive     <= 8'd0;
        end else if (i_step) begin
            r_playing   <= n_playing;
            r_steady_on <= n_steady_on;
            r_idx       <= n_idx;
            r_cyc       <= n_cyc;
            r_elapsed   <= n_elapsed;
            r_drive     <= n_drive;
        end
    end

    // Result of the item in flight
    assign o_result.drive_level = n_drive;
    assign o_result.busy_res    = n_steady_on || n_playing;

    `PPP_ASSERT_NOW(a_idle_state_clean, !r_playing, (r_idx == 2'd0) && (r_elapsed == '0) && (r_cyc == CYC_ONE), "idle player holds stale element state")
    `PPP_ASSERT_NOW(a_cycle_nonzero, 1'b1, r_cyc != '0, "cycle number reached zero")

endmodule

`default_nettype wire
